@@ rtl/core/brb_pkg.sv @@
// Shared types, codes and constants of the byte ring buffer.
package brb_pkg;

  // Field widths fixed by the interface
  localparam int LEN_W = 11;
  localparam int CNT_W = 10;
  localparam int BYTE_W = 8;

  // Defaults and limits
  localparam int DEPTH_DEF = 1024;
  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
  localparam int MIN_LEN = 2;

  // Internal queue depths (powers of two)
  localparam int CQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_CW = $clog2(OQ_DEPTH) + 1;

  // Request codes
  localparam logic [2:0] REQ_WRITE  = 3'd0;
  localparam logic [2:0] REQ_READ   = 3'd1;
  localparam logic [2:0] REQ_FLUSH  = 3'd2;
  localparam logic [2:0] REQ_ADV_RD = 3'd3;
  localparam logic [2:0] REQ_ADV_WR = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_FLUSH,
    OP_ADV_RD,
    OP_ADV_WR,
    OP_QUERY
  } brb_op_t;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [BYTE_W-1:0] wr_data;
    logic [CNT_W-1:0]  adjust_count;
    logic              burst_last;
  } brb_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rd_data;
    logic              rd_valid;
    logic [1:0]        status;
    logic [CNT_W-1:0]  fill_count;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  read_run;
    logic [CNT_W-1:0]  write_run;
    logic              burst_end;
  } brb_out_t;

  // Classified command passed from front to back; count already clamped
  typedef struct packed {
    brb_op_t           op;
    logic [BYTE_W-1:0] wr_data;
    logic [CNT_W-1:0]  count;
    logic              burst_last;
  } brb_cmd_t;

endpackage

@@ rtl/core/brb_ram.sv @@
// Generic single-port-write, registered-read RAM.
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/brb_fifo.sv @@
// Small register FIFO used for the command queue and the result queue.
module brb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/brb_front.sv @@
// Front end: takes request items, decodes the request and clamps the adjust count.
module brb_front #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                 push,
  output logic                 full,
  input  brb_pkg::brb_in_t     in_data,
  input  logic [((($clog2(DEPTH)) > brb_pkg::LEN_W) ? $clog2(DEPTH) : brb_pkg::LEN_W)-1:0] len,
  input  logic                 cq_full,
  output logic                 cq_push,
  output brb_pkg::brb_cmd_t    cmd
);

  import brb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int W  = (AW > LEN_W) ? AW : LEN_W;

  logic [W-1:0] cnt_ext;
  logic [W-1:0] len_m1;
  logic [W-1:0] cnt_clamped;

  // Transfer into the command queue
  assign full    = cq_full;
  assign cq_push = push && !cq_full;

  // Clamp the move to one less than the length in use
  assign cnt_ext     = W'(in_data.adjust_count);
  assign len_m1      = len - 1'b1;
  assign cnt_clamped = (cnt_ext > len_m1) ? len_m1 : cnt_ext;

  // Classify the request; unused codes behave as a query
  always_comb begin
    cmd.wr_data    = in_data.wr_data;
    cmd.count      = CNT_W'(cnt_clamped);
    cmd.burst_last = in_data.burst_last;
    case (in_data.req_type)
      REQ_WRITE:  cmd.op = OP_WRITE;
      REQ_READ:   cmd.op = OP_READ;
      REQ_FLUSH:  cmd.op = OP_FLUSH;
      REQ_ADV_RD: cmd.op = OP_ADV_RD;
      REQ_ADV_WR: cmd.op = OP_ADV_WR;
      default:    cmd.op = OP_QUERY;
    endcase
  end

endmodule

@@ rtl/core/brb_back.sv @@
// Back end: owns the pointers and the byte store, executes commands, builds results.
module brb_back #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [((($clog2(DEPTH)) > brb_pkg::LEN_W) ? $clog2(DEPTH) : brb_pkg::LEN_W)-1:0] len,
  input  logic                       cfg_clear,
  input  logic                       cmd_valid,
  input  brb_pkg::brb_cmd_t          cmd,
  output logic                       cmd_pop,
  input  logic [brb_pkg::OQ_CW-1:0]  oq_count,
  output logic                       res_push,
  output brb_pkg::brb_out_t          res,
  output logic                       busy
);

  import brb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int W  = (AW > LEN_W) ? AW : LEN_W;

  function automatic logic [W-1:0] fill_f(input logic [W-1:0] w, input logic [W-1:0] r,
                                          input logic [W-1:0] l);
    if (w >= r) begin
      return w - r;
    end
    return l + w - r;
  endfunction

  function automatic logic [W-1:0] inc_wrap(input logic [W-1:0] p, input logic [W-1:0] l);
    logic [W-1:0] q;
    q = p + 1'b1;
    return (q == l) ? '0 : q;
  endfunction

  function automatic logic [W-1:0] add_wrap(input logic [W-1:0] p, input logic [W-1:0] c,
                                            input logic [W-1:0] l);
    logic [W:0] s;
    s = {1'b0, p} + {1'b0, c};
    if (s >= {1'b0, l}) begin
      s = s - {1'b0, l};
    end
    return W'(s);
  endfunction

  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     rp_r, rp_nxt;
  logic [W-1:0]      wpx, rpx;
  logic [W-1:0]      fill_now;
  logic [W-1:0]      len_m1;
  logic [W-1:0]      base_w;
  logic              fire;
  logic              credit;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_q;
  logic [1:0]        st;
  logic              rdv;

  logic              b2_valid_r;
  logic              b2_rdv_r;
  logic [1:0]        b2_st_r;
  logic              b2_burst_r;

  logic [W-1:0]      free_now;
  logic [W-1:0]      rd_room, wr_room;
  logic [W-1:0]      rrun, wrun;

  assign wpx    = W'(wp_r);
  assign rpx    = W'(rp_r);
  assign len_m1 = len - 1'b1;

  // Fill from the current pointers; used for decisions and for the result stage
  assign fill_now = fill_f(wpx, rpx, len);

  // Issue only when the result queue has room for everything in flight
  assign credit  = ({1'b0, oq_count} + (OQ_CW+1)'(b2_valid_r)) < (OQ_CW+1)'(OQ_DEPTH);
  assign fire    = cmd_valid && credit;
  assign cmd_pop = fire;
  assign busy    = cmd_valid || b2_valid_r;

  // Execute stage: pointer update and store access
  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = wp_r;
    st        = ST_OK;
    rdv       = 1'b0;
    base_w    = (fill_now == '0) ? '0 : wpx;
    case (cmd.op)
      OP_WRITE: begin
        // an empty buffer restarts at zero before the byte goes in
        if (fill_now == '0) begin
          rp_nxt = '0;
        end
        if (fill_now == len_m1) begin
          st = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(base_w);
          wp_nxt    = AW'(inc_wrap(base_w, len));
        end
      end
      OP_READ: begin
        if (fill_now == '0) begin
          st = ST_EMPTY;
        end else begin
          ram_re = 1'b1;
          rdv    = 1'b1;
          rp_nxt = AW'(inc_wrap(rpx, len));
        end
      end
      OP_FLUSH: begin
        wp_nxt = '0;
        rp_nxt = '0;
      end
      OP_ADV_RD: begin
        rp_nxt = AW'(add_wrap(rpx, W'(cmd.count), len));
      end
      OP_ADV_WR: begin
        wp_nxt = AW'(add_wrap(wpx, W'(cmd.count), len));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      rp_r       <= '0;
      b2_valid_r <= 1'b0;
    end else begin
      if (cfg_clear) begin
        wp_r <= '0;
        rp_r <= '0;
      end else if (fire) begin
        wp_r <= wp_nxt;
        rp_r <= rp_nxt;
      end
      b2_valid_r <= fire;
    end
  end

  // Per-item flags carried into the result stage
  always_ff @(posedge clk) begin
    if (fire) begin
      b2_rdv_r   <= rdv;
      b2_st_r    <= st;
      b2_burst_r <= cmd.burst_last;
    end
  end

  brb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (fire && ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.wr_data),
    .re    (fire && ram_re),
    .raddr (rp_r),
    .rdata (ram_q)
  );

  // Result stage: counts from the pointers as the item left them
  assign free_now = len_m1 - fill_now;
  assign rd_room  = len - rpx;
  assign wr_room  = len - wpx;
  assign rrun     = (fill_now < rd_room) ? fill_now : rd_room;
  assign wrun     = (free_now < wr_room) ? free_now : wr_room;

  assign res_push       = b2_valid_r;
  assign res.rd_data    = b2_rdv_r ? ram_q : '0;
  assign res.rd_valid   = b2_rdv_r;
  assign res.status     = b2_st_r;
  assign res.fill_count = CNT_W'(fill_now);
  assign res.free_count = CNT_W'(free_now);
  assign res.read_run   = CNT_W'(rrun);
  assign res.write_run  = CNT_W'(wrun);
  assign res.burst_end  = b2_burst_r;

endmodule

@@ rtl/core/byte_ring_buffer.sv @@
// Byte ring buffer top level: length register, command queue, front, back, result queue.
//
// Byte ring buffer with one slot always kept empty. Requests enter through a
// push/full queue port and every request produces exactly one result on the
// empty/pop queue port. Sustained rate is one request per clock while the
// result queue is not backed up; the limit is the pointer update in the back
// end, which settles both pointers for one request each cycle. A result
// becomes visible once its request has passed the command queue, the execute
// stage and the push into the result queue. Reads come from a registered-read
// byte RAM of DEPTH entries; its contents are undefined until written and no
// clearing pass is run. The length register is written over the cfg channel,
// which is ready only while no request is in flight; a write empties the
// buffer.
module byte_ring_buffer #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  brb_pkg::brb_in_t            in_data,
  output logic                        empty,
  input  logic                        pop,
  output brb_pkg::brb_out_t           out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [brb_pkg::LEN_W-1:0]   cfg_data
);

  import brb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int W  = (AW > LEN_W) ? AW : LEN_W;

  logic [LEN_W-1:0] cfg_len_r;
  logic [W:0]       len_ext;
  logic [W-1:0]     len;
  logic             cfg_xfer;
  logic             busy;

  brb_cmd_t         cq_wdata, cq_rdata;
  logic             cq_push, cq_pop, cq_full, cq_empty;
  logic [$clog2(CQ_DEPTH):0] cq_count;

  brb_out_t         res;
  logic             res_push;
  logic             oq_full;
  logic [OQ_CW-1:0] oq_count;

  // Length register
  assign cfg_ready = !busy;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= LEN_RESET;
    end else if (cfg_xfer) begin
      cfg_len_r <= cfg_data;
    end
  end

  // Length in use, clamped to the legal range
  assign len_ext = (W+1)'(cfg_len_r);
  always_comb begin
    if (len_ext < (W+1)'(MIN_LEN)) begin
      len = W'(MIN_LEN);
    end else if (len_ext > (W+1)'(DEPTH)) begin
      len = W'(DEPTH);
    end else begin
      len = W'(len_ext);
    end
  end

  brb_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .len     (len),
    .cq_full (cq_full),
    .cq_push (cq_push),
    .cmd     (cq_wdata)
  );

  brb_fifo #(
    .WIDTH ($bits(brb_cmd_t)),
    .DEPTH (CQ_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (cq_wdata),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .full  (cq_full),
    .empty (cq_empty),
    .count (cq_count)
  );

  brb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .len       (len),
    .cfg_clear (cfg_xfer),
    .cmd_valid (!cq_empty),
    .cmd       (cq_rdata),
    .cmd_pop   (cq_pop),
    .oq_count  (oq_count),
    .res_push  (res_push),
    .res       (res),
    .busy      (busy)
  );

  brb_fifo #(
    .WIDTH ($bits(brb_out_t)),
    .DEPTH (OQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .pop   (pop),
    .rdata (out_data),
    .full  (oq_full),
    .empty (empty),
    .count (oq_count)
  );

`ifndef SYNTHESIS
  // Credit check: a finished result always finds room in the result queue
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !oq_full)
    else $error("result pushed into a full result queue");

  // The back end only takes commands that are present
  a_cmd_present: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |-> !cq_empty && cq_count != '0)
    else $error("command taken from an empty queue");

  // A delivered byte always comes with an ok status
  a_rd_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.rd_valid) |-> out_data.status == ST_OK)
    else $error("read data with a non-ok status");

  // The length register only changes while nothing is in flight
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_xfer |=> !res_push)
    else $error("length written with a request in flight");
`endif

endmodule

@@ test/byte_ring_buffer_test.sv @@
// Self-checking testbench for the byte ring buffer: shadow ring, request driver, result checker.
module byte_ring_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import brb_pkg::*;

  // Request codes with no package name; the block treats them as a query
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  // Request-to-result latency of the block, used to size the idle waits
  localparam int unsigned LATENCY = 3;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned N_PHASES = 12;

  // Length settings per phase, with the request count for each
  localparam logic [LEN_W-1:0] LEN_PLAN [N_PHASES] = '{
    11'd2, 11'd0, 11'd5, 11'd2047, 11'd3, 11'd1,
    11'd16, 11'd1024, 11'd9, 11'd1025, 11'd64, 11'd4
  };
  localparam int unsigned ITEMS_PLAN [N_PHASES] = '{
    110, 110, 110, 60, 110, 110, 110, 60, 110, 60, 100, 110
  };

  // Shadow copy of the ring: predicts each result and checks what comes out
  class ring_shadow;
    bit [BYTE_W-1:0] mem [DEPTH_DEF];
    bit              written [DEPTH_DEF];
    int unsigned     wr_ptr;
    int unsigned     rd_ptr;
    int unsigned     len;
    brb_out_t        due_status [$];
    int unsigned     errors;
    int unsigned     n_req;
    int unsigned     n_res;
    int unsigned     n_wr;
    int unsigned     n_rd;
    int unsigned     n_full;
    int unsigned     n_empty;
    int unsigned     n_adv;

    function new();
      len = DEPTH_DEF;
      wr_ptr = 0;
      rd_ptr = 0;
      errors = 0;
      n_req = 0;
      n_res = 0;
      n_wr = 0;
      n_rd = 0;
      n_full = 0;
      n_empty = 0;
      n_adv = 0;
    endfunction

    // Length write: clamp into range and empty the ring
    function void set_length(logic [LEN_W-1:0] v);
      if (v < MIN_LEN) len = MIN_LEN;
      else if (v > DEPTH_DEF) len = DEPTH_DEF;
      else len = v;
      wr_ptr = 0;
      rd_ptr = 0;
    endfunction

    function int unsigned fill_level();
      return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : len + wr_ptr - rd_ptr;
    endfunction

    // Pointer move: clamp to len-1, wrap at most once
    function int unsigned moved_ptr(int unsigned ptr, int unsigned count);
      int unsigned c;
      int unsigned p;
      c = (count > len - 1) ? len - 1 : count;
      p = ptr + c;
      if (p >= len) p -= len;
      return p;
    endfunction

    // A read either finds the ring empty or lands on a byte stored earlier
    function bit read_safe();
      return fill_level() == 0 || written[rd_ptr];
    endfunction

    // Accepted request: update the shadow and queue the result it must produce
    function void take_request(brb_in_t req);
      brb_out_t    r;
      int unsigned f;
      int unsigned fr;
      r = '0;
      r.status = ST_OK;
      r.burst_end = req.burst_last;
      n_req++;
      case (req.req_type)
        REQ_WRITE: begin
          // empty ring restarts at slot zero
          if (fill_level() == 0) begin
            wr_ptr = 0;
            rd_ptr = 0;
          end
          if (len - 1 - fill_level() == 0) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            mem[wr_ptr] = req.wr_data;
            written[wr_ptr] = 1'b1;
            wr_ptr = (wr_ptr + 1 >= len) ? 0 : wr_ptr + 1;
            n_wr++;
          end
        end
        REQ_READ: begin
          if (fill_level() == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
          end else begin
            r.rd_data = mem[rd_ptr];
            r.rd_valid = 1'b1;
            rd_ptr = (rd_ptr + 1 >= len) ? 0 : rd_ptr + 1;
            n_rd++;
          end
        end
        REQ_FLUSH: begin
          wr_ptr = 0;
          rd_ptr = 0;
        end
        REQ_ADV_RD: begin
          rd_ptr = moved_ptr(rd_ptr, req.adjust_count);
          n_adv++;
        end
        REQ_ADV_WR: begin
          wr_ptr = moved_ptr(wr_ptr, req.adjust_count);
          n_adv++;
        end
        default: begin
          // query and spare codes leave the ring alone
        end
      endcase
      f = fill_level();
      fr = len - 1 - f;
      r.fill_count = CNT_W'(f);
      r.free_count = CNT_W'(fr);
      r.read_run = CNT_W'((f < len - rd_ptr) ? f : len - rd_ptr);
      r.write_run = CNT_W'((fr < len - wr_ptr) ? fr : len - wr_ptr);
      due_status.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 40) $display("MISMATCH %s", msg);
      errors++;
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, want %0h", n_res, name, got, want));
    endtask

    // Result transfer: compare with the oldest outstanding prediction
    task match_result(brb_out_t got);
      brb_out_t want;
      if (due_status.size() == 0) begin
        report($sformatf("result with nothing outstanding: %h", got));
        return;
      end
      want = due_status.pop_front();
      n_res++;
      check_field("rd_data", 16'(got.rd_data), 16'(want.rd_data));
      check_field("rd_valid", 16'(got.rd_valid), 16'(want.rd_valid));
      check_field("status", 16'(got.status), 16'(want.status));
      check_field("fill_count", 16'(got.fill_count), 16'(want.fill_count));
      check_field("free_count", 16'(got.free_count), 16'(want.free_count));
      check_field("read_run", 16'(got.read_run), 16'(want.read_run));
      check_field("write_run", 16'(got.write_run), 16'(want.write_run));
      check_field("burst_end", 16'(got.burst_end), 16'(want.burst_end));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic push;
  logic full;
  brb_in_t in_data;
  logic empty;
  logic pop;
  brb_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [LEN_W-1:0] cfg_data;

  ring_shadow shadow;

  // Sender burst/gap control and receiver stall pattern
  bit          gap_on;
  int unsigned run_left;
  int unsigned burst_left;
  bit          burst_write;
  int unsigned pop_mode;
  logic [15:0] stall_mask;
  int unsigned mask_idx;
  int unsigned hold_left;
  int unsigned n_cfg;
  int unsigned cycles;

  byte_ring_buffer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, shadow.due_status.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: check each transfer, then choose pop for the next cycle
  always @(posedge clk) begin
    if (rst_n && pop && !empty) shadow.match_result(out_data);
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      case (pop_mode)
        0: pop <= 1'b1;
        1: begin
          pop <= stall_mask[mask_idx % 16];
          mask_idx++;
        end
        2: pop <= ($urandom_range(0, 2) != 0);
        default: begin
          // mostly popping, with occasional long holds
          if (hold_left != 0) begin
            pop <= 1'b0;
            hold_left--;
          end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 15) == 0) hold_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  function automatic brb_in_t mk_req(logic [2:0] op, logic [BYTE_W-1:0] data,
                                     logic [CNT_W-1:0] cnt, logic last);
    brb_in_t req;
    req.req_type = op;
    req.wr_data = data;
    req.adjust_count = cnt;
    req.burst_last = last;
    return req;
  endfunction

  // Next random request: write and read bursts with random content, plus odd single requests
  function automatic brb_in_t next_request();
    brb_in_t     req;
    int unsigned pick;
    int unsigned maxb;
    req = mk_req(OP_QUERY, BYTE_W'($urandom), CNT_W'($urandom), 1'($urandom));
    if (burst_left == 0) begin
      pick = $urandom_range(0, 99);
      maxb = (shadow.len <= 16) ? shadow.len + 3 : 24;
      if (pick < 40) begin
        burst_write = 1'b1;
        burst_left = $urandom_range(1, maxb);
      end else if (pick < 78) begin
        burst_write = 1'b0;
        burst_left = $urandom_range(1, maxb);
      end
    end
    if (burst_left > 0) begin
      burst_left--;
      req.req_type = burst_write ? REQ_WRITE : REQ_READ;
      req.burst_last = (burst_left == 0);
    end else begin
      pick = $urandom_range(0, 21);
      if (pick < 4) req.req_type = REQ_FLUSH;
      else if (pick < 9) req.req_type = REQ_ADV_RD;
      else if (pick < 14) req.req_type = REQ_ADV_WR;
      else if (pick < 17) req.req_type = OP_QUERY;
      else if (pick == 17) req.req_type = REQ_SPARE_LO;
      else if (pick == 18) req.req_type = REQ_SPARE_HI;
      else if (pick == 19) req.req_type = REQ_READ;
      else req.req_type = REQ_WRITE;
      // pointer moves: extremes, in-range counts, anything
      case ($urandom_range(0, 3))
        0: req.adjust_count = '0;
        1: req.adjust_count = '1;
        2: req.adjust_count = CNT_W'($urandom_range(0, shadow.len));
        default: ;
      endcase
    end
    // never read a slot that was only skipped over by a pointer move
    if (req.req_type == REQ_READ && !shadow.read_safe()) req.req_type = OP_QUERY;
    return req;
  endfunction

  // Drive one request and hold it until the transfer
  task automatic send_request(brb_in_t req);
    if (gap_on && run_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      run_left = $urandom_range(1, 24);
    end
    if (run_left > 0) run_left--;
    push <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (full);
    shadow.take_request(req);
  endtask

  task automatic wait_all_results();
    push <= 1'b0;
    while (shadow.due_status.size() != 0) @(posedge clk);
  endtask

  // Length register write, only with the block idle
  task automatic write_length(logic [LEN_W-1:0] v);
    wait_all_results();
    repeat (2 * LATENCY) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow.set_length(v);
    n_cfg++;
  endtask

  initial begin
    int unsigned ph;
    int unsigned i;
    shadow = new();
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    gap_on = 1'b0;
    run_left = 0;
    burst_left = 0;
    burst_write = 1'b0;
    pop_mode = 0;
    stall_mask = 16'hffff;
    mask_idx = 0;
    hold_left = 0;
    n_cfg = 0;
    cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at reset length, no idling on either side
    send_request(mk_req(REQ_READ, 8'h00, 10'd0, 1'b1));    // read while empty
    send_request(mk_req(OP_QUERY, 8'h00, 10'd0, 1'b0));
    send_request(mk_req(REQ_WRITE, 8'h00, 10'd0, 1'b0));
    send_request(mk_req(REQ_WRITE, 8'hff, 10'd0, 1'b0));
    send_request(mk_req(REQ_WRITE, 8'ha5, 10'd0, 1'b1));
    send_request(mk_req(REQ_READ, 8'h00, 10'd0, 1'b0));
    send_request(mk_req(REQ_READ, 8'h00, 10'd0, 1'b0));
    send_request(mk_req(REQ_READ, 8'h00, 10'd0, 1'b1));
    send_request(mk_req(REQ_READ, 8'h00, 10'd0, 1'b0));    // drained again
    send_request(mk_req(REQ_ADV_RD, 8'h00, 10'd0, 1'b0));
    send_request(mk_req(REQ_WRITE, 8'h5a, 10'd0, 1'b1));   // empty: pointers restart
    send_request(mk_req(REQ_READ, 8'h00, 10'd0, 1'b1));
    send_request(mk_req(REQ_FLUSH, 8'h00, 10'd0, 1'b0));
    send_request(mk_req(REQ_ADV_WR, 8'h00, 10'd1023, 1'b0)); // ring now full
    send_request(mk_req(REQ_WRITE, 8'h77, 10'd0, 1'b1));   // dropped, full
    send_request(mk_req(REQ_ADV_RD, 8'h00, 10'd1023, 1'b0));
    send_request(mk_req(REQ_ADV_RD, 8'h00, 10'd1023, 1'b0)); // wraps
    send_request(mk_req(REQ_ADV_WR, 8'h00, 10'd5, 1'b1));    // wraps
    send_request(mk_req(REQ_SPARE_LO, 8'hff, 10'd1023, 1'b1));
    send_request(mk_req(REQ_SPARE_HI, 8'h00, 10'd0, 1'b0));
    send_request(mk_req(REQ_FLUSH, 8'hff, 10'd1023, 1'b1));

    // Random phases, one length setting each
    for (ph = 0; ph < N_PHASES; ph++) begin
      write_length(LEN_PLAN[ph]);
      gap_on = ($urandom_range(0, 3) != 0);
      run_left = 0;
      burst_left = 0;
      pop_mode = $urandom_range(0, 3);
      stall_mask = 16'($urandom) | 16'h0001;
      for (i = 0; i < ITEMS_PLAN[ph]; i++) begin
        // one full drain in mid-stream
        if (ph == 1 && i == ITEMS_PLAN[ph] / 2) wait_all_results();
        send_request(next_request());
      end
    end

    wait_all_results();
    repeat (4 * LATENCY) @(posedge clk);

    $display("covered %0d requests over %0d length settings, %0d results checked, %0d mismatches",
             shadow.n_req, n_cfg, shadow.n_res, shadow.errors);
    $display("stored %0d bytes, read back %0d, %0d full drops, %0d empty reads, %0d pointer moves",
             shadow.n_wr, shadow.n_rd, shadow.n_full, shadow.n_empty, shadow.n_adv);
    if (shadow.errors == 0 && shadow.due_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/brb_pkg.sv
rtl/core/brb_ram.sv
rtl/core/brb_fifo.sv
rtl/core/brb_front.sv
rtl/core/brb_back.sv
rtl/core/byte_ring_buffer.sv
test/byte_ring_buffer_test.sv
